FILE: hw/rtl/dq_pkg.sv
// Shared types and constants for the deque with remove-by-value.
// No dependencies; imported by every other file of the block.
package dq_pkg;

  localparam int DATA_W = 32;
  localparam int OPC_W  = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] removed_value;
    status_t           status;
  } res_t;

endpackage

FILE: hw/rtl/dq_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on dq_pkg for the field widths.
interface dq_req_if;
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

interface dq_rsp_if #(parameter int CNT_W = 7);
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] removed_value;
  logic [1:0]               status;
  logic [CNT_W-1:0]         occupancy;

  modport source (output valid, removed_value, status, occupancy, input ready);
  modport sink   (input valid, removed_value, status, occupancy, output ready);
endinterface

FILE: hw/rtl/dq_ram.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on dq_pkg for the data width.
module dq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [dq_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [dq_pkg::DATA_W-1:0] rdata
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/dq_seq.sv
// Sequencer: ring pointers, opcode decode, front-to-back scan and gap close.
// Depends on dq_pkg; drives the ports of dq_ram.
module dq_seq #(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [dq_pkg::OPC_W-1:0]  req_opcode,
  input  logic [dq_pkg::DATA_W-1:0] req_value,
  output logic                      res_valid,
  input  logic                      res_ready,
  output dq_pkg::res_t              res,
  output logic [CNT_W-1:0]          res_occupancy,
  output logic                      mem_we,
  output logic [IDX_W-1:0]          mem_waddr,
  output logic [dq_pkg::DATA_W-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [IDX_W-1:0]          mem_raddr,
  input  logic [dq_pkg::DATA_W-1:0] mem_rdata
);
  import dq_pkg::*;

  localparam int SUM_W = IDX_W + 1;

  seq_state_t        state, state_next;
  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  wr_idx, wr_idx_next;
  logic              chk_valid, chk_valid_next;
  logic [DATA_W-1:0] val, val_next;
  logic [DATA_W-1:0] res_value, res_value_next;
  status_t           res_status, res_status_next;
  logic              full;

  // Ring position of a logical index; the sum stays below twice the capacity.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] logical);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(logical);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign full = (count == CNT_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    wr_idx     <= wr_idx_next;
    val        <= val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    idx_next        = idx;
    wr_idx_next     = wr_idx;
    chk_valid_next  = chk_valid;
    val_next        = val;
    res_value_next  = res_value;
    res_status_next = res_status;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          val_next        = req_value;
          res_value_next  = '0;
          res_status_next = ST_OK;
          state_next      = S_RESULT;
          case (req_opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                front_next = (front == '0) ? IDX_W'(CAPACITY - 1) : front - 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = front_next;
                mem_wdata  = req_value;
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = slot(front, count);
                mem_wdata  = req_value;
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = front;
                front_next = slot(front, CNT_W'(1));
                count_next = count - 1'b1;
                state_next = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = slot(front, count - 1'b1);
                count_next = count - 1'b1;
                state_next = S_READ;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                idx_next       = '0;
                chk_valid_next = 1'b0;
                state_next     = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        res_value_next = mem_rdata;
        state_next     = S_RESULT;
      end

      // Issue one read a cycle; compare the entry read in the cycle before.
      S_SCAN: begin
        if (chk_valid && mem_rdata == val) begin
          res_value_next = mem_rdata;
          wr_idx_next    = idx - 1'b1;
          chk_valid_next = 1'b0;
          state_next     = S_SHIFT;
        end else if (idx == count) begin
          res_status_next = ST_NOT_FOUND;
          chk_valid_next  = 1'b0;
          state_next      = S_RESULT;
        end else begin
          mem_re         = 1'b1;
          mem_raddr      = slot(front, idx);
          idx_next       = idx + 1'b1;
          chk_valid_next = 1'b1;
        end
      end

      // Move each later entry one place toward the front.
      S_SHIFT: begin
        if (chk_valid) begin
          mem_we      = 1'b1;
          mem_waddr   = slot(front, wr_idx);
          mem_wdata   = mem_rdata;
          wr_idx_next = wr_idx + 1'b1;
        end
        if (idx < count) begin
          mem_re         = 1'b1;
          mem_raddr      = slot(front, idx);
          idx_next       = idx + 1'b1;
          chk_valid_next = 1'b1;
        end else begin
          chk_valid_next = 1'b0;
          if (!chk_valid) begin
            count_next = count - 1'b1;
            state_next = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign res.removed_value = res_value;
  assign res.status        = res_status;
  assign res_occupancy     = count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_holds_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(count) && $stable(front))
    else $error("ring pointers moved during scan");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && mem_we) |-> (wr_idx < idx))
    else $error("gap close write overtook its read");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_FULL) |-> full)
    else $error("full status with free space");

  a_result_handoff: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after handoff");

endmodule

FILE: hw/rtl/deque_with_remove_by_value_core.sv
// Deque of signed 32-bit values in a ring, with remove-by-value.
// Push, empty, full or unknown opcode: result passes S_RESULT to the output register.
// No new request is taken until the result leaves S_RESULT. Pop adds a read in S_READ.
// Remove scans through the single read port of the entry RAM, then closes the gap.
// Reset (rst, synchronous) empties the deque; the entry RAM is not cleared.
// Depends on dq_pkg, dq_if, dq_ram and dq_seq.
module deque_with_remove_by_value_core #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic              res_valid, res_ready;
  res_t              res;
  logic [CNT_W-1:0]  res_occupancy;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              out_valid;
  res_t              out_res;
  logic [CNT_W-1:0]  out_occupancy;

  dq_seq #(
    .CAPACITY(CAPACITY),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_opcode   (req.opcode),
    .req_value    (req.value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .res_occupancy(res_occupancy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  dq_ram #(
    .DEPTH(CAPACITY),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: load when empty or being drained.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res       <= res;
      out_occupancy <= res_occupancy;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.removed_value = out_res.removed_value;
  assign rsp.status        = out_res.status;
  assign rsp.occupancy     = out_occupancy;

endmodule
